// File: hdl/sha256_byte_stream_hasher_core_macros.svh
// assertion macros for the sha-256 hasher
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SHA_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/sha256_pkg.sv
`timescale 1ns / 1ps
package sha256_pkg;
	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	localparam logic CMD_ABSORB = 1'b0;
	localparam logic CMD_FINISH = 1'b1;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	// control from sequencer to round unit
	typedef struct packed {
		logic       load;   // copy hash into working regs
		logic       round;  // run one round
		logic [5:0] t;
		logic       fold;   // add working regs into hash
		logic       init;   // restore initial hash
	} rnd_ctl_t;

	typedef logic [31:0] word_t;

	function automatic word_t init_h(input logic [2:0] i);
		word_t h;
		case (i)
			3'd0: h = 32'h6a09e667;
			3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372;
			3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f;
			3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic word_t round_k(input logic [5:0] t);
		word_t k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t rotr(input word_t v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction
endpackage

// File: hdl/sha256_round.sv
`timescale 1ns / 1ps
// one shared compression round with a rolling 16-word message schedule
module sha256_round (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sha256_pkg::rnd_ctl_t        ctl,
	input  sha256_pkg::word_t           blk_word,
	input  logic [2:0]                  hash_sel,
	output sha256_pkg::word_t           hash_word
);
	sha256_pkg::word_t hash_q [8];
	sha256_pkg::word_t wrk_q [8];
	sha256_pkg::word_t win_q [16];
	sha256_pkg::word_t w, x15, x2, g0, g1, s0, s1, ch, mj, t1, t2;

	// schedule word for this round
	always_comb begin
		x15 = win_q[4'(ctl.t - 6'd15)];
		x2 = win_q[4'(ctl.t - 6'd2)];
		g0 = sha256_pkg::rotr(x15, 7) ^ sha256_pkg::rotr(x15, 18) ^ (x15 >> 3);
		g1 = sha256_pkg::rotr(x2, 17) ^ sha256_pkg::rotr(x2, 19) ^ (x2 >> 10);
		if (ctl.t < 6'd16) begin
			w = blk_word;
		end else begin
			w = win_q[ctl.t[3:0]] + g0 + win_q[4'(ctl.t - 6'd7)] + g1;
		end
		s1 = sha256_pkg::rotr(wrk_q[4], 6) ^ sha256_pkg::rotr(wrk_q[4], 11)
			^ sha256_pkg::rotr(wrk_q[4], 25);
		ch = (wrk_q[4] & wrk_q[5]) ^ (~wrk_q[4] & wrk_q[6]);
		t1 = wrk_q[7] + s1 + ch + sha256_pkg::round_k(ctl.t) + w;
		s0 = sha256_pkg::rotr(wrk_q[0], 2) ^ sha256_pkg::rotr(wrk_q[0], 13)
			^ sha256_pkg::rotr(wrk_q[0], 22);
		mj = (wrk_q[0] & wrk_q[1]) ^ (wrk_q[0] & wrk_q[2]) ^ (wrk_q[1] & wrk_q[2]);
		t2 = s0 + mj;
	end

	// schedule window and working registers
	always_ff @(posedge clk) begin
		if (ctl.round) begin
			win_q[ctl.t[3:0]] <= w;
			wrk_q[7] <= wrk_q[6];
			wrk_q[6] <= wrk_q[5];
			wrk_q[5] <= wrk_q[4];
			wrk_q[4] <= wrk_q[3] + t1;
			wrk_q[3] <= wrk_q[2];
			wrk_q[2] <= wrk_q[1];
			wrk_q[1] <= wrk_q[0];
			wrk_q[0] <= t1 + t2;
		end else if (ctl.load) begin
			for (int i = 0; i < 8; i++) wrk_q[i] <= hash_q[i];
		end
	end

	// chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::init_h(3'(i));
		end else if (ctl.init) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::init_h(3'(i));
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + wrk_q[i];
		end
	end

	assign hash_word = hash_q[hash_sel];
endmodule

// File: hdl/sha256_byte_stream_hasher_core.sv
`timescale 1ns / 1ps
// absorb: one byte per cycle while idle; every 64th byte starts a compression (load, 64 rounds, fold)
// finish: pad sweep and compression, repeated with a zero and length sweep when the length spills,
// then 8 digest items, one per cycle when taken
// the single shared round unit runs every compression, and no byte is taken while it runs
// not ready while padding, compressing or emitting; the block buffer is a 16x32 memory
// arst_n restores initial hash, clears byte and bit counts; buffer and schedule not cleared
module sha256_byte_stream_hasher_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sha256_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sha256_pkg::out_item_t out_data
);
`include "sha256_byte_stream_hasher_core_macros.svh"

	typedef enum logic [2:0] {
		S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FOLD, S_EMIT
	} state_t;

	state_t state_q;
	logic [5:0] fill_q;
	logic [63:0] bits_q;
	logic [5:0] t_q;
	logic [5:0] pad_pos_q;
	logic final_q;   // this compression holds the length
	logic spill_q;   // spill block pending
	logic [2:0] emit_q;
	logic pad_first_q;   // first sweep word carries the pad byte
	sha256_pkg::word_t mem [16];
	sha256_pkg::word_t rd_q;
	sha256_pkg::rnd_ctl_t ctl;
	sha256_pkg::word_t hash_word;
	logic [3:0] wr_addr, rd_addr;
	logic [31:0] wr_word;
	logic [3:0] wr_be;
	logic wr_en;
	logic accept;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	assign out_data.digest_word = hash_word;
	assign out_data.word_index = emit_q;
	assign out_data.last_word = (emit_q == 3'd7);

	// buffer write: byte lanes on absorb; pad sweep writes the pad word from the pad lane on, then whole words
	always_comb begin
		wr_en = 1'b0;
		wr_addr = fill_q[5:2];
		wr_be = 4'b0000;
		wr_word = {4{in_data.data_byte}};
		if (state_q == S_IDLE && accept && in_data.cmd == sha256_pkg::CMD_ABSORB) begin
			wr_en = 1'b1;
			wr_be = 4'b1000 >> fill_q[1:0];
		end else if (state_q == S_PAD) begin
			wr_en = 1'b1;
			wr_addr = pad_pos_q[5:2];
			wr_be = 4'b1111 >> pad_pos_q[1:0];
			if (pad_pos_q[5:2] == 4'd14 && final_q) begin
				wr_word = bits_q[63:32];
				wr_be = 4'b1111;
			end else if (pad_pos_q[5:2] == 4'd15 && final_q) begin
				wr_word = bits_q[31:0];
				wr_be = 4'b1111;
			end else begin
				wr_word = '0;
				// on the first sweep word the lane at the pad position gets 0x80, else the word is zeros
				if (pad_first_q) begin
					wr_word = {sha256_pkg::PAD_BYTE, 24'h000000} >> {pad_pos_q[1:0], 3'b000};
				end
			end
		end
	end

	// block buffer memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int b = 0; b < 4; b++) begin
				if (wr_be[3 - b]) mem[wr_addr][31 - 8*b -: 8] <= wr_word[31 - 8*b -: 8];
			end
		end
		rd_q <= mem[rd_addr];
	end

	// read one word ahead of the round that consumes it
	always_comb begin
		if (state_q == S_ROUND) rd_addr = 4'(t_q + 6'd1);
		else rd_addr = 4'd0;
	end

	always_comb begin
		ctl.load = (state_q == S_LOAD);
		ctl.round = (state_q == S_ROUND);
		ctl.t = t_q;
		ctl.fold = (state_q == S_FOLD);
		ctl.init = (state_q == S_EMIT) && out_ready && (emit_q == 3'd7);
	end

	sha256_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.blk_word (rd_q),
		.hash_sel (emit_q),
		.hash_word(hash_word)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			bits_q <= '0;
			t_q <= '0;
			pad_pos_q <= '0;
			final_q <= 1'b0;
			spill_q <= 1'b0;
			emit_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_data.cmd == sha256_pkg::CMD_ABSORB) begin
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + 64'd8;
							final_q <= 1'b0;
							if (fill_q == 6'd63) state_q <= S_LOAD;
						end else begin
							// pad byte lands first, then zero sweep from next byte
							state_q <= S_PAD;
							pad_pos_q <= fill_q;
							spill_q <= (fill_q >= sha256_pkg::LEN_POS);
							final_q <= (fill_q < sha256_pkg::LEN_POS);
						end
					end
				end
				S_PAD: begin
					// first write of the sweep after a finish item is the word holding the pad byte
					if (pad_pos_q[5:2] == 4'd15) begin
						state_q <= S_LOAD;
						pad_pos_q <= '0;
					end else begin
						pad_pos_q <= {pad_pos_q[5:2] + 4'd1, 2'b00};
					end
				end
				S_LOAD: begin
					t_q <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					t_q <= t_q + 6'd1;
					if (t_q == 6'd63) state_q <= S_FOLD;
				end
				S_FOLD: begin
					if (!spill_q && !final_q) begin
						state_q <= S_IDLE;
					end else if (spill_q) begin
						spill_q <= 1'b0;
						final_q <= 1'b1;
						state_q <= S_PAD;
						pad_pos_q <= '0;
					end else begin
						state_q <= S_EMIT;
						emit_q <= '0;
					end
				end
				S_EMIT: begin
					if (out_ready) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							state_q <= S_IDLE;
							fill_q <= '0;
							bits_q <= '0;
							final_q <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// marks the first sweep cycle after a finish item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pad_first_q <= 1'b0;
		else pad_first_q <= accept && in_data.cmd == sha256_pkg::CMD_FINISH;
	end

	`SHA_ASSERT_NEXT(a_no_in_busy, clk, arst_n, state_q != S_IDLE,
		!accept || state_q == S_IDLE, "item taken while busy")
	`SHA_ASSERT_IMPL(a_out_only_emit, clk, arst_n,
		out_valid |-> state_q == S_EMIT && !in_ready, "output while ready")
	`SHA_ASSERT_NEXT(a_fill_wrap, clk, arst_n,
		state_q == S_IDLE && accept && in_data.cmd == sha256_pkg::CMD_ABSORB
		&& fill_q == 6'd63, state_q == S_LOAD, "full buffer not compressed")
endmodule

// File: tb/sv/sha256_byte_stream_hasher_core_tb.sv
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_core_tb;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	sha256_pkg::in_item_t  in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	sha256_pkg::out_item_t out_data;

	sha256_byte_stream_hasher_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #1 clk = ~clk;

	// round constants and initial hash, kept locally
	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	// predictor state
	logic [31:0] hv [8];
	logic [7:0]  blk [64];
	logic [5:0]  nbytes;
	logic [63:0] nbits;

	sha256_pkg::in_item_t  pending_items [$];
	sha256_pkg::out_item_t digest_fifo [$];
	int        errors = 0;
	int        n_sent = 0;
	int        n_words = 0;
	int        n_msgs = 0;
	bit        hold_in = 0;

	function automatic logic [31:0] ror(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
				+ w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
		a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
		e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
		for (int t = 0; t < 64; t++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ K_TAB[t] + w[t];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
		hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
	endtask

	task automatic restart_message();
		for (int i = 0; i < 8; i++) hv[i] = H_INIT[i];
		nbytes = '0;
		nbits = '0;
	endtask

	// advance the predictor by one accepted item
	task automatic hash_item(input sha256_pkg::in_item_t it);
		int p;
		sha256_pkg::out_item_t o;
		if (it.cmd == sha256_pkg::CMD_ABSORB) begin
			blk[nbytes] = it.data_byte;
			nbits += 64'd8;
			nbytes += 6'd1;
			if (nbytes == 0) compress_block();
		end else begin
			p = int'(nbytes);
			blk[p] = sha256_pkg::PAD_BYTE;
			p++;
			if (p > sha256_pkg::LEN_POS) begin
				for (int i = p; i < 64; i++) blk[i] = 8'h00;
				compress_block();
				p = 0;
			end
			for (int i = p; i < sha256_pkg::LEN_POS; i++) blk[i] = 8'h00;
			for (int i = 0; i < 8; i++) blk[sha256_pkg::LEN_POS + i] = nbits[63 - 8*i -: 8];
			compress_block();
			for (int i = 0; i < 8; i++) begin
				o.digest_word = hv[i];
				o.word_index = i[2:0];
				o.last_word = (i == 7);
				digest_fifo.push_back(o);
			end
			n_msgs++;
			restart_message();
		end
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic add_msg(input int len);
		sha256_pkg::in_item_t it;
		for (int i = 0; i < len; i++) begin
			it.cmd = sha256_pkg::CMD_ABSORB;
			it.data_byte = 8'($urandom_range(0, 255));
			pending_items.push_back(it);
		end
		it.cmd = sha256_pkg::CMD_FINISH;
		it.data_byte = 8'($urandom_range(0, 255));
		pending_items.push_back(it);
	endtask

	// driver: inputs change on the falling edge
	int in_gap = 0;
	bit in_phase = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_phase) begin
				// accepted at the last rising edge
				n_sent++;
			end
			if (!in_valid || in_phase) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0 && !hold_in) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
					in_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 :
				(($urandom_range(0, 60) == 0) ? 1'b0 : 1'b1);
		end
	end

	// sample handshakes at the rising edge
	always @(posedge clk) begin
		in_phase <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) hash_item(in_data);
		if (arst_n && out_valid && out_ready) begin
			n_words++;
			if (digest_fifo.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected digest word %h idx %0d",
					out_data.digest_word, out_data.word_index);
			end else begin
				sha256_pkg::out_item_t e;
				e = digest_fifo.pop_front();
				if (e !== out_data) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
							e.digest_word, e.word_index, e.last_word,
							out_data.digest_word, out_data.word_index, out_data.last_word);
				end
			end
		end
	end

	// stimulus
	initial begin
		int len, r;
		restart_message();
		for (int i = 0; i < 64; i++) blk[i] = 8'h00;
		// directed: empty messages, a two-byte message of extreme bytes, short messages
		add_msg(0);
		begin
			sha256_pkg::in_item_t it;
			it.cmd = sha256_pkg::CMD_ABSORB; it.data_byte = 8'h00; pending_items.push_back(it);
			it.data_byte = 8'hff; pending_items.push_back(it);
			it.cmd = sha256_pkg::CMD_FINISH; it.data_byte = 8'hff; pending_items.push_back(it);
			it.cmd = sha256_pkg::CMD_FINISH; it.data_byte = 8'h00; pending_items.push_back(it);
		end
		add_msg(3);
		add_msg(9);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// directed long messages around padding boundaries
		add_msg(55);
		add_msg(56);
		add_msg(63);
		add_msg(64);
		// random messages, mostly short
		while (pending_items.size() + n_sent < 370) begin
			r = $urandom_range(0, 9);
			len = (r < 6) ? $urandom_range(0, 20) : $urandom_range(50, 70);
			add_msg(len);
		end
		// hold the sender once until the digests drain
		wait (n_sent >= 200);
		hold_in = 1;
		wait (digest_fifo.size() == 0 && !in_valid);
		hold_in = 0;
		wait (pending_items.size() == 0 && !in_valid && n_sent > 0);
		wait (digest_fifo.size() == 0);
		repeat (200) @(posedge clk);
		$display("covered %0d input items, %0d messages, %0d digest words",
			n_sent, n_msgs, n_words);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
